// File: src/local_address_table_assert.svh
// assertion macros shared by the local address table modules
// expects clk and rst_n in scope at the point of use
`ifndef LOCAL_ADDRESS_TABLE_ASSERT_SVH
`define LOCAL_ADDRESS_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LAT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LAT_ASSERT(lbl, prop, msg)
`define LAT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: src/lat_pkg.sv
// shared types and constants for the local address table
// no dependencies
`default_nettype none

package lat_pkg;

  localparam int DefTableDepth = 16;
  localparam int CountOutW     = 5;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_ADD      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_PURGE    = 3'd3,
    OP_CLASSIFY = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_INSERTED  = 4'd0,
    ST_PRESENT   = 4'd1,
    ST_FULL      = 4'd2,
    ST_REMOVED   = 4'd3,
    ST_NOT_FOUND = 4'd4,
    ST_PURGED    = 4'd5,
    ST_CLEARED   = 4'd6,
    ST_OUTBOUND  = 4'd7,
    ST_INBOUND   = 4'd8,
    ST_FOREIGN   = 4'd9
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address_a;
    logic [31:0] address_b;
    logic        static_flag;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [4:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        mark;
  } entry_t;

  // table write address source
  typedef enum logic [1:0] {
    WA_CHK   = 2'd0,
    WA_IDX   = 2'd1,
    WA_COUNT = 2'd2
  } wa_sel_t;

  // table write data source
  typedef enum logic [1:0] {
    WD_MERGE = 2'd0,
    WD_REQ   = 2'd1,
    WD_RD    = 2'd2
  } wd_sel_t;

  typedef struct packed {
    logic    req_load;
    logic    idx_clr;
    logic    scan_en;
    logic    idx_inc;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    ra_last;
    logic    we;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    res_load;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] operation;
    logic       full;
    logic       idx_lt_cnt;
    logic       cnt_zero;
    logic       rd_mark;
    logic       hit_a;
    logic       scan_end;
    logic       found_b;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/lat_dp.sv
// datapath of the local address table: entry memory, count, walk index,
// compare logic and result register; uses lat_pkg and the assertion macros
`default_nettype none
`include "local_address_table_assert.svh"

module lat_dp #(
  parameter int TABLE_DEPTH = lat_pkg::DefTableDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lat_pkg::req_t in_req,
  input  wire lat_pkg::cmd_t cmd_i,
  output lat_pkg::sts_t      sts_o,
  input  wire logic          out_ready,
  output logic               out_valid,
  output lat_pkg::res_t      out_res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int OW = lat_pkg::CountOutW;

  lat_pkg::entry_t mem [TABLE_DEPTH];
  lat_pkg::entry_t rd_data_r;
  lat_pkg::entry_t wd;
  logic [AW-1:0]   wa;
  logic [AW-1:0]   ra;

  lat_pkg::req_t    req_r;
  lat_pkg::status_t res_status_r;
  lat_pkg::res_t    out_res_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    last_idx;
  logic [AW-1:0]    chk_idx_r, chk_idx_nxt;
  logic             chk_r, chk_nxt;
  logic             found_b_r, found_b_nxt;
  logic             issue, match_a, match_b, idx_lt_cnt;

  assign last_idx   = count_r - CW'(1);
  assign idx_lt_cnt = idx_r < count_r;
  assign issue      = cmd_i.scan_en & idx_lt_cnt;
  assign match_a    = rd_data_r.addr == req_r.address_a;
  assign match_b    = rd_data_r.addr == req_r.address_b;
  assign ra         = cmd_i.ra_last ? last_idx[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    case (cmd_i.wa_sel)
      lat_pkg::WA_CHK:   wa = chk_idx_r;
      lat_pkg::WA_IDX:   wa = idx_r[AW-1:0];
      lat_pkg::WA_COUNT: wa = count_r[AW-1:0];
      default:           wa = chk_idx_r;
    endcase
    case (cmd_i.wd_sel)
      lat_pkg::WD_MERGE: wd = '{addr: rd_data_r.addr,
                                mark: rd_data_r.mark | req_r.static_flag};
      lat_pkg::WD_REQ:   wd = '{addr: req_r.address_a, mark: req_r.static_flag};
      lat_pkg::WD_RD:    wd = rd_data_r;
      default:           wd = rd_data_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd_i.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd_i.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end

    idx_nxt = idx_r;
    if (cmd_i.idx_clr) begin
      idx_nxt = '0;
    end else if (issue || cmd_i.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end

    chk_nxt     = issue;
    chk_idx_nxt = issue ? idx_r[AW-1:0] : chk_idx_r;

    found_b_nxt = found_b_r;
    if (cmd_i.idx_clr) begin
      found_b_nxt = 1'b0;
    end else if (cmd_i.scan_en && chk_r && match_b) begin
      found_b_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd_i.we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      chk_r       <= 1'b0;
      found_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= chk_nxt;
      found_b_r   <= found_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    if (cmd_i.req_load) begin
      req_r <= in_req;
    end
    if (cmd_i.res_load) begin
      res_status_r <= cmd_i.res_code;
    end
    if (cmd_i.out_load) begin
      out_res_r.status      <= res_status_r;
      out_res_r.entry_count <= OW'(count_r);
    end
  end

  always_comb begin
    sts_o.operation  = req_r.operation;
    sts_o.full       = count_r == CW'(TABLE_DEPTH);
    sts_o.idx_lt_cnt = idx_lt_cnt;
    sts_o.cnt_zero   = count_r == '0;
    sts_o.rd_mark    = rd_data_r.mark;
    sts_o.hit_a      = chk_r & match_a;
    sts_o.scan_end   = (chk_r & match_a) | (!chk_r & !idx_lt_cnt);
    sts_o.found_b    = found_b_r;
    sts_o.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `LAT_ASSERT(a_cnt_range, count_r <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `LAT_ASSERT(a_cnt_inc, cmd_i.cnt_inc |=> count_r == CW'($past(count_r) + 1'b1), "count did not step up")
  `LAT_ASSERT_RST(a_out_reset, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

// File: src/lat_ctrl.sv
// controller of the local address table: sequences scans, moves and the
// purge walk over the datapath; uses lat_pkg and the assertion macros
`default_nettype none
`include "local_address_table_assert.svh"

module lat_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lat_pkg::sts_t sts_i,
  output lat_pkg::cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_START  = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_RDLAST = 10'b0000001000,
    S_MOVE   = 10'b0000010000,
    S_PK_RD  = 10'b0000100000,
    S_PK_CHK = 10'b0001000000,
    S_PL_RD  = 10'b0010000000,
    S_PL_CHK = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.req_load = 1'b1;
          state_nxt      = S_START;
        end
      end
      S_START: begin
        unique case (sts_i.operation) inside
          lat_pkg::OP_CLEAR: begin
            cmd_o.cnt_clr  = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = lat_pkg::ST_CLEARED;
            state_nxt      = S_OUT;
          end
          lat_pkg::OP_ADD: begin
            if (sts_i.full) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = lat_pkg::ST_FULL;
              state_nxt      = S_OUT;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          lat_pkg::OP_REMOVE, lat_pkg::OP_CLASSIFY: begin
            cmd_o.idx_clr = 1'b1;
            state_nxt     = S_SCAN;
          end
          lat_pkg::OP_PURGE: begin
            cmd_o.idx_clr = 1'b1;
            state_nxt     = S_PK_RD;
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = lat_pkg::ST_NOT_FOUND;
            state_nxt      = S_OUT;
          end
        endcase
      end
      S_SCAN: begin
        // reads stream one per cycle; the compare works on the registered read data
        cmd_o.scan_en = !sts_i.scan_end;
        if (sts_i.hit_a) begin
          unique case (sts_i.operation) inside
            lat_pkg::OP_ADD: begin
              cmd_o.we       = 1'b1;
              cmd_o.wa_sel   = lat_pkg::WA_CHK;
              cmd_o.wd_sel   = lat_pkg::WD_MERGE;
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = lat_pkg::ST_PRESENT;
              state_nxt      = S_OUT;
            end
            lat_pkg::OP_REMOVE: begin
              state_nxt = S_RDLAST;
            end
            default: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = lat_pkg::ST_OUTBOUND;
              state_nxt      = S_OUT;
            end
          endcase
        end else if (sts_i.scan_end) begin
          cmd_o.res_load = 1'b1;
          state_nxt      = S_OUT;
          unique case (sts_i.operation) inside
            lat_pkg::OP_ADD: begin
              cmd_o.we       = 1'b1;
              cmd_o.wa_sel   = lat_pkg::WA_COUNT;
              cmd_o.wd_sel   = lat_pkg::WD_REQ;
              cmd_o.cnt_inc  = 1'b1;
              cmd_o.res_code = lat_pkg::ST_INSERTED;
            end
            lat_pkg::OP_REMOVE: begin
              cmd_o.res_code = lat_pkg::ST_NOT_FOUND;
            end
            default: begin
              cmd_o.res_code = sts_i.found_b ? lat_pkg::ST_INBOUND : lat_pkg::ST_FOREIGN;
            end
          endcase
        end
      end
      S_RDLAST: begin
        cmd_o.ra_last = 1'b1;
        state_nxt     = S_MOVE;
      end
      S_MOVE: begin
        // last entry overwrites the matched slot
        cmd_o.we       = 1'b1;
        cmd_o.wa_sel   = lat_pkg::WA_CHK;
        cmd_o.wd_sel   = lat_pkg::WD_RD;
        cmd_o.cnt_dec  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = lat_pkg::ST_REMOVED;
        state_nxt      = S_OUT;
      end
      S_PK_RD: begin
        if (sts_i.idx_lt_cnt) begin
          state_nxt = S_PK_CHK;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = lat_pkg::ST_PURGED;
          state_nxt      = S_OUT;
        end
      end
      S_PK_CHK: begin
        if (sts_i.rd_mark) begin
          cmd_o.idx_inc = 1'b1;
          state_nxt     = S_PK_RD;
        end else begin
          state_nxt = S_PL_RD;
        end
      end
      S_PL_RD: begin
        if (sts_i.cnt_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = lat_pkg::ST_PURGED;
          state_nxt      = S_OUT;
        end else begin
          cmd_o.ra_last = 1'b1;
          state_nxt     = S_PL_CHK;
        end
      end
      S_PL_CHK: begin
        cmd_o.cnt_dec = 1'b1;
        if (sts_i.rd_mark) begin
          // static tail entry fills the dynamic slot, even past the count
          cmd_o.we      = 1'b1;
          cmd_o.wa_sel  = lat_pkg::WA_IDX;
          cmd_o.wd_sel  = lat_pkg::WD_RD;
          cmd_o.idx_inc = 1'b1;
          state_nxt     = S_PK_RD;
        end else begin
          state_nxt = S_PL_RD;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LAT_ASSERT(a_cnt_cmd_onehot, $onehot0({cmd_o.cnt_clr, cmd_o.cnt_inc, cmd_o.cnt_dec}), "conflicting count commands")
  `LAT_ASSERT(a_inc_not_full, cmd_o.cnt_inc |-> !sts_i.full, "append into a full table")
  `LAT_ASSERT(a_done_to_idle, cmd_o.out_load |=> in_ready, "not ready after result hand-off")

endmodule

`default_nettype wire

// File: src/local_address_table.sv
// Local address table, top level.
// Holds up to TABLE_DEPTH local host addresses, each with a static mark.
// Input channel in_valid/in_ready/in_req carries one request: clear, add,
// remove, purge dynamic entries or classify a packet by source/destination.
// Result channel out_valid/out_ready/out_res returns one status and the
// entry count for every request, in request order.
// Requests are handled one at a time. Clear, unused codes and an add to a
// full table go straight from the start state to the result; add, remove
// and classify walk the valid entries through the single read port of the
// entry memory (removing the last entry is slowest); purge reads and checks
// each visited slot and each dropped or moved entry. With a ready receiver
// the next request is taken in the cycle its predecessor's result appears.
// A finished result sits in an output register; the next request is taken
// once that result has been moved there, so a stalled receiver holds at most
// one finished result and one request in work.
// Reset (rst_n low, synchronous) empties the table at once: the count is
// cleared and no memory sweep is needed.
// uses lat_pkg, lat_ctrl and lat_dp
`default_nettype none

module local_address_table #(
  parameter int TABLE_DEPTH = lat_pkg::DefTableDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lat_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lat_pkg::res_t      out_res
);

  lat_pkg::cmd_t cmd;
  lat_pkg::sts_t sts;

  lat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  lat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

// File: tb/sv/local_address_table_tb.sv
`timescale 1ns / 1ps
// testbench for local_address_table: a directed stimulus table, then random requests;
// typed rows held to set results, others to a behavioral host list model kept here
// depends on lat_pkg and the local_address_table rtl

module local_address_table_tb;

  localparam int HostDepth   = 16;
  localparam int PoolSize    = 24;
  localparam int RandomCount = 1320;
  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 100;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    lat_pkg::req_t req;
    bit            typed;
    lat_pkg::res_t want;
  } plan_row_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  lat_pkg::req_t in_req    = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  lat_pkg::res_t out_res;

  // model of the host list
  logic [31:0] host_addr   [HostDepth];
  bit          host_static [HostDepth];
  int          host_count;

  lat_pkg::res_t awaited_status [$];
  plan_row_t     plan [$];
  logic [31:0]   addr_pool [PoolSize];
  bit            calm = 1'b0;
  int            mismatch_count = 0;
  int            idle_cycles = 0;

  local_address_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic int find_host(input logic [31:0] addr);
    for (int i = 0; i < host_count; i++)
      if (host_addr[i] == addr) return i;
    return -1;
  endfunction

  function automatic void move_last_into(input int pos);
    int last;
    last = host_count - 1;
    host_addr[pos]    = host_addr[last];
    host_static[pos]  = host_static[last];
    host_addr[last]   = '0;
    host_static[last] = 1'b0;
    host_count        = last;
  endfunction

  function automatic lat_pkg::res_t predict_status(input lat_pkg::req_t r);
    lat_pkg::status_t st;
    int               pos;
    int               k;
    lat_pkg::res_t    res;
    st = lat_pkg::ST_NOT_FOUND;
    case (r.operation)
      lat_pkg::OP_CLEAR: begin
        for (int i = 0; i < HostDepth; i++) begin
          host_addr[i]   = '0;
          host_static[i] = 1'b0;
        end
        host_count = 0;
        st = lat_pkg::ST_CLEARED;
      end
      lat_pkg::OP_ADD: begin
        if (host_count >= HostDepth) begin
          st = lat_pkg::ST_FULL;
        end else begin
          pos = find_host(r.address_a);
          if (pos >= 0) begin
            host_static[pos] = host_static[pos] | r.static_flag;
            st = lat_pkg::ST_PRESENT;
          end else begin
            host_addr[host_count]   = r.address_a;
            host_static[host_count] = r.static_flag;
            host_count++;
            st = lat_pkg::ST_INSERTED;
          end
        end
      end
      lat_pkg::OP_REMOVE: begin
        pos = find_host(r.address_a);
        if (pos >= 0) begin
          move_last_into(pos);
          st = lat_pkg::ST_REMOVED;
        end
      end
      lat_pkg::OP_PURGE: begin
        // trailing dynamic entries are dropped first; when everything from k on
        // was dynamic the static entry just below k lands past the count and is lost
        k = 0;
        while (k < host_count) begin
          if (!host_static[k]) begin
            while (host_count != 0 && !host_static[host_count - 1]) host_count--;
            if (host_count != 0) move_last_into(k);
          end
          k++;
        end
        st = lat_pkg::ST_PURGED;
      end
      lat_pkg::OP_CLASSIFY: begin
        if (find_host(r.address_a) >= 0) st = lat_pkg::ST_OUTBOUND;
        else if (find_host(r.address_b) >= 0) st = lat_pkg::ST_INBOUND;
        else st = lat_pkg::ST_FOREIGN;
      end
      default: st = lat_pkg::ST_NOT_FOUND;
    endcase
    res.status      = st;
    res.entry_count = 5'(host_count);
    return res;
  endfunction

  function automatic plan_row_t mk_row(input logic [2:0] op, input logic [31:0] a,
                                       input logic [31:0] b, input bit flag,
                                       input bit typed = 1'b0,
                                       input lat_pkg::status_t st = lat_pkg::ST_NOT_FOUND,
                                       input int cnt = 0);
    plan_row_t row;
    row.req.operation   = op;
    row.req.address_a   = a;
    row.req.address_b   = b;
    row.req.static_flag = flag;
    row.typed            = typed;
    row.want.status      = st;
    row.want.entry_count = 5'(cnt);
    return row;
  endfunction

  // entry 0 all ones and static, entry 1 all zeros, the rest dynamic
  function automatic logic [31:0] fill_addr(input int i);
    if (i == 0) return 32'hFFFF_FFFF;
    if (i == 1) return 32'h0000_0000;
    return {8'h0a, 8'(i), 8'h5a, 8'(i)};
  endfunction

  function automatic logic [31:0] pick_addr(input int pool_pct);
    if ($urandom_range(99) < pool_pct) return addr_pool[$urandom_range(PoolSize - 1)];
    return $urandom;
  endfunction

  function automatic lat_pkg::req_t draw_request();
    lat_pkg::req_t r;
    int            roll;
    roll          = $urandom_range(99);
    r.address_a   = pick_addr(80);
    r.address_b   = pick_addr(60);
    r.static_flag = 1'($urandom_range(1));
    if (roll < 42) r.operation = lat_pkg::OP_ADD;
    else if (roll < 57) r.operation = lat_pkg::OP_REMOVE;
    else if (roll < 87) r.operation = lat_pkg::OP_CLASSIFY;
    else if (roll < 92) r.operation = lat_pkg::OP_PURGE;
    else if (roll < 94) r.operation = lat_pkg::OP_CLEAR;
    else r.operation = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    return r;
  endfunction

  task automatic send_request(input lat_pkg::req_t r, input bit typed,
                              input lat_pkg::res_t want);
    lat_pkg::res_t model;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = predict_status(r);
    awaited_status.push_back(typed ? want : model);
  endtask

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 24);

  always @(posedge clk) begin : check_results
    lat_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d count %0d",
                                  out_res.status, out_res.entry_count));
      end else begin
        want = awaited_status.pop_front();
        if (out_res.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_res.status, want.status));
        if (out_res.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    out_res.entry_count, want.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("local_address_table: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    lat_pkg::res_t none;
    none = '0;
    for (int i = 0; i < HostDepth; i++) begin
      host_addr[i]   = '0;
      host_static[i] = 1'b0;
    end
    host_count = 0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < PoolSize; i++) addr_pool[i] = $urandom;

    // empty list right after reset
    plan.push_back(mk_row(lat_pkg::OP_CLASSIFY, '0, '0, 1'b0, 1'b1,
                          lat_pkg::ST_FOREIGN, 0));
    plan.push_back(mk_row(lat_pkg::OP_REMOVE, '0, '0, 1'b0, 1'b1,
                          lat_pkg::ST_NOT_FOUND, 0));
    plan.push_back(mk_row(lat_pkg::OP_PURGE, '0, '0, 1'b0, 1'b1,
                          lat_pkg::ST_PURGED, 0));
    plan.push_back(mk_row(OP_UNUSED_HI, '1, '1, 1'b1, 1'b1, lat_pkg::ST_NOT_FOUND, 0));
    // fill to capacity, with one add of an address already held
    for (int i = 0; i < HostDepth; i++) begin
      if (i == HostDepth - 1)
        plan.push_back(mk_row(lat_pkg::OP_ADD, fill_addr(0), '0, 1'b0));
      plan.push_back(mk_row(lat_pkg::OP_ADD, fill_addr(i), '0, i == 0));
    end
    // full wins over present
    plan.push_back(mk_row(lat_pkg::OP_ADD, fill_addr(0), '0, 1'b1, 1'b1,
                          lat_pkg::ST_FULL, HostDepth));
    plan.push_back(mk_row(lat_pkg::OP_ADD, 32'h1234_5678, '0, 1'b0, 1'b1,
                          lat_pkg::ST_FULL, HostDepth));
    plan.push_back(mk_row(lat_pkg::OP_CLASSIFY, fill_addr(0), 32'h0000_0000, 1'b0));
    plan.push_back(mk_row(lat_pkg::OP_CLASSIFY, 32'h5555_AAAA,
                          fill_addr(HostDepth - 1), 1'b0));
    plan.push_back(mk_row(lat_pkg::OP_REMOVE, fill_addr(7), '0, 1'b0));
    // only entry 0 is static and all behind it dynamic: the static entry is lost
    plan.push_back(mk_row(lat_pkg::OP_PURGE, '0, '0, 1'b0));
    plan.push_back(mk_row(lat_pkg::OP_CLASSIFY, fill_addr(0), 32'h0000_0000, 1'b0));
    plan.push_back(mk_row(lat_pkg::OP_CLEAR, '1, '1, 1'b1, 1'b1,
                          lat_pkg::ST_CLEARED, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].want);
    for (int n = 0; n < RandomCount; n++) begin
      calm = (n >= 500 && n < 800);
      send_request(draw_request(), 1'b0, none);
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("local_address_table: match");
    end else begin
      $display("local_address_table: mismatch");
    end
    $finish;
  end

endmodule
